/* hdl/jsvl_pkg.sv */
// ----------------------------------------------------------------------------
// jsvl_pkg
// Shared types and constants of the joint step velocity limiter: item
// formats, register indexes and the command and status groups between
// the controller and the datapath.
// ----------------------------------------------------------------------------
package jsvl_pkg;

  // joint slots carried on the ports, and the default number of live joints
  localparam int unsigned JOINT_SLOTS     = 6;
  localparam int unsigned JOINT_COUNT_DEF = 6;
  localparam int unsigned IDX_W           = $clog2(JOINT_SLOTS);

  // field widths
  localparam int unsigned POS_W      = 32;
  localparam int unsigned LIMIT_W    = 32;
  localparam int unsigned PERIOD_W   = 24;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 2;

  // bound product is Q16.40, the Q16.16 bound is its upper part
  localparam int unsigned BPROD_W = LIMIT_W + PERIOD_W;
  localparam int unsigned FRAC_SH = 24;

  // serial divider: one quotient bit per cycle, quotient as wide as the bound
  localparam int unsigned DIV_STEPS = LIMIT_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // register reset values
  localparam logic [LIMIT_W-1:0]  DEF_LIMIT_RST = 32'd78643;
  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 24'd167772;

  // saturation limits of a commanded angle
  localparam logic [POS_W-1:0] POS_MAX = 32'h7fff_ffff;
  localparam logic [POS_W-1:0] POS_MIN = 32'h8000_0000;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLOSED_LOOP   = 2'd0,
    CFG_DEFAULT_LIMIT = 2'd1,
    CFG_UPDATE_PERIOD = 2'd2
  } cfg_idx_e;

  // input transaction
  typedef struct packed {
    logic signed [POS_W-1:0] target_0;
    logic signed [POS_W-1:0] target_1;
    logic signed [POS_W-1:0] target_2;
    logic signed [POS_W-1:0] target_3;
    logic signed [POS_W-1:0] target_4;
    logic signed [POS_W-1:0] target_5;
    logic [LIMIT_W-1:0]      velocity_limit;
    logic                    use_default_limit;
    logic                    traj_active;
  } in_item_t;

  // output transaction
  typedef struct packed {
    logic signed [POS_W-1:0] commanded_0;
    logic signed [POS_W-1:0] commanded_1;
    logic signed [POS_W-1:0] commanded_2;
    logic signed [POS_W-1:0] commanded_3;
    logic signed [POS_W-1:0] commanded_4;
    logic signed [POS_W-1:0] commanded_5;
    logic                    moved;
    logic                    was_scaled;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic             load;
    logic             prep;
    logic             max_step;
    logic             chk;
    logic             mul;
    logic             div_step;
    logic             add;
    logic             out_load;
    logic [IDX_W-1:0] idx;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic active;
    logic exceeds;
    logic scaled;
  } dp_status_t;

endpackage

/* hdl/jsvl_chan_if.sv */
// ----------------------------------------------------------------------------
// jsvl_chan_if
// Valid/ready channel carrying one payload per transaction.
// ----------------------------------------------------------------------------
interface jsvl_chan_if #(
  parameter type payload_t = logic
) ();

  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);

endinterface

/* hdl/joint_step_velocity_limiter_top.sv */
// an ignored step goes straight to the output register; an unscaled step adds the
// max search and a saturating update per joint, a scaled one also a multiply and
// a serial division per joint; one transaction at a time, with the serial divider
// giving one quotient bit per cycle
// reset: commanded positions clear to zero, configuration registers take their reset values
// ----------------------------------------------------------------------------
// joint_step_velocity_limiter_top
// Steps up to six commanded joint angles towards their targets with the largest
// step limited by velocity times update period, keeping direction.
// ----------------------------------------------------------------------------
module joint_step_velocity_limiter_top
  import jsvl_pkg::*;
#(
  parameter int unsigned JOINT_COUNT = JOINT_COUNT_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  jsvl_chan_if.sink             in_chan_i,
  jsvl_chan_if.source           out_chan_o
);

  dp_cmd_t    cmd;
  dp_status_t status;
  in_item_t   in_item;
  out_item_t  out_item;
  logic       in_ready;
  logic       out_valid;

  assign in_item = in_chan_i.payload;

  // sequencer
  jsvl_ctrl #(
    .JOINT_COUNT (JOINT_COUNT)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_chan_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (out_chan_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath
  jsvl_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_item_o  (out_item)
  );

  // channel hookup
  assign in_chan_i.ready    = in_ready;
  assign out_chan_o.valid   = out_valid;
  assign out_chan_o.payload = out_item;

endmodule

/* hdl/jsvl_datapath.sv */
// ----------------------------------------------------------------------------
// jsvl_datapath
// Configuration registers, commanded positions, delta and bound registers,
// shared multiplier, serial divider, saturating adder and output register.
// ----------------------------------------------------------------------------
module jsvl_datapath
  import jsvl_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  in_item_t              in_item_i,
  input  dp_cmd_t               cmd_i,
  output dp_status_t            status_o,
  output out_item_t             out_item_o
);

  // configuration registers
  logic                closed_loop_q;
  logic [LIMIT_W-1:0]  def_limit_q;
  logic [PERIOD_W-1:0] period_q;

  // per-transaction control flags
  logic active_q, active_d;
  logic scale_q, scale_d;

  // state and working registers
  logic [POS_W-1:0]   cmd_q [JOINT_SLOTS];
  logic [POS_W-1:0]   mag_q [JOINT_SLOTS];
  logic               neg_q [JOINT_SLOTS];
  logic [LIMIT_W-1:0] limit_q;
  logic [LIMIT_W-1:0] bound_q;
  logic [POS_W-1:0]   vmax_q;
  logic [POS_W-1:0]   rem_q, rem_d;
  logic [POS_W-1:0]   quo_q, quo_d;
  out_item_t          out_q;

  // combinational values
  logic [POS_W-1:0]     tgt [JOINT_SLOTS];
  logic [POS_W:0]       diff [JOINT_SLOTS];
  logic [POS_W:0]       abs_diff [JOINT_SLOTS];
  logic [LIMIT_W-1:0]   lim_sel;
  logic [BPROD_W-1:0]   bound_prod;
  logic [2*POS_W-1:0]   scale_prod;
  logic [POS_W:0]       shifted;
  logic [POS_W:0]       trial;
  logic                 ge;
  logic [POS_W-1:0]     step_mag;
  logic [POS_W+1:0]     step_val;
  logic [POS_W+1:0]     sum;
  logic [POS_W-1:0]     sat_val;
  logic                 exceeds;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      closed_loop_q <= 1'b0;
      def_limit_q   <= DEF_LIMIT_RST;
      period_q      <= PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CLOSED_LOOP:   closed_loop_q <= cfg_wdata_i[0];
        CFG_DEFAULT_LIMIT: def_limit_q   <= cfg_wdata_i[LIMIT_W-1:0];
        CFG_UPDATE_PERIOD: period_q      <= cfg_wdata_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
  end

  // targets as an array
  assign tgt[0] = in_item_i.target_0;
  assign tgt[1] = in_item_i.target_1;
  assign tgt[2] = in_item_i.target_2;
  assign tgt[3] = in_item_i.target_3;
  assign tgt[4] = in_item_i.target_4;
  assign tgt[5] = in_item_i.target_5;

  // per-joint exact deltas and their magnitudes
  always_comb begin
    for (int k = 0; k < JOINT_SLOTS; k++) begin
      diff[k]     = {tgt[k][POS_W-1], tgt[k]} - {cmd_q[k][POS_W-1], cmd_q[k]};
      abs_diff[k] = diff[k][POS_W] ? ((POS_W+1)'(0) - diff[k]) : diff[k];
    end
  end

  // limit select and step bound product
  assign lim_sel    = in_item_i.use_default_limit ? def_limit_q : in_item_i.velocity_limit;
  assign bound_prod = BPROD_W'(limit_q) * BPROD_W'(period_q);
  assign exceeds    = vmax_q > bound_q;

  // shared multiplier for the scaled magnitude
  assign scale_prod = (2*POS_W)'(mag_q[cmd_i.idx]) * (2*POS_W)'(bound_q);

  // restoring divider step
  always_comb begin
    shifted = {rem_q, quo_q[POS_W-1]};
    ge      = shifted >= {1'b0, vmax_q};
    trial   = shifted - {1'b0, vmax_q};
    rem_d   = ge ? trial[POS_W-1:0] : shifted[POS_W-1:0];
    quo_d   = {quo_q[POS_W-2:0], ge};
    if (cmd_i.mul) begin
      rem_d = scale_prod[2*POS_W-1:POS_W];
      quo_d = scale_prod[POS_W-1:0];
    end
  end

  // signed step and saturating add
  always_comb begin
    step_mag = scale_q ? quo_q : mag_q[cmd_i.idx];
    step_val = neg_q[cmd_i.idx] ? ((POS_W+2)'(0) - (POS_W+2)'(step_mag))
                                : (POS_W+2)'(step_mag);
    sum      = {{2{cmd_q[cmd_i.idx][POS_W-1]}}, cmd_q[cmd_i.idx]} + step_val;
    if (sum[POS_W+1:POS_W-1] == 3'b000 || sum[POS_W+1:POS_W-1] == 3'b111) begin
      sat_val = sum[POS_W-1:0];
    end else if (sum[POS_W+1]) begin
      sat_val = POS_MIN;
    end else begin
      sat_val = POS_MAX;
    end
  end

  // control flags
  always_comb begin
    active_d = active_q;
    scale_d  = scale_q;
    if (cmd_i.load) begin
      active_d = closed_loop_q & ~in_item_i.traj_active;
      scale_d  = 1'b0;
    end else if (cmd_i.chk) begin
      scale_d  = exceeds;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      scale_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      scale_q  <= scale_d;
    end
  end

  // commanded positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < JOINT_SLOTS; k++) begin
        cmd_q[k] <= '0;
      end
    end else if (cmd_i.add) begin
      cmd_q[cmd_i.idx] <= sat_val;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      for (int k = 0; k < JOINT_SLOTS; k++) begin
        mag_q[k] <= abs_diff[k][POS_W-1:0];
        neg_q[k] <= diff[k][POS_W];
      end
      limit_q <= lim_sel;
    end
    if (cmd_i.prep) begin
      bound_q <= bound_prod[FRAC_SH +: LIMIT_W];
      vmax_q  <= '0;
    end
    if (cmd_i.max_step && (mag_q[cmd_i.idx] > vmax_q)) begin
      vmax_q <= mag_q[cmd_i.idx];
    end
    if (cmd_i.mul || cmd_i.div_step) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q.commanded_0 <= cmd_q[0];
      out_q.commanded_1 <= cmd_q[1];
      out_q.commanded_2 <= cmd_q[2];
      out_q.commanded_3 <= cmd_q[3];
      out_q.commanded_4 <= cmd_q[4];
      out_q.commanded_5 <= cmd_q[5];
      out_q.moved       <= active_q;
      out_q.was_scaled  <= scale_q;
    end
  end

  assign out_item_o       = out_q;
  assign status_o.active  = active_q;
  assign status_o.exceeds = exceeds;
  assign status_o.scaled  = scale_q;

endmodule

/* hdl/jsvl_ctrl.sv */
// ----------------------------------------------------------------------------
// jsvl_ctrl
// Sequencer of the limiter: max search over the joints, then per joint a
// multiply and a serial division when scaling, and a saturating update.
// ----------------------------------------------------------------------------
module jsvl_ctrl
  import jsvl_pkg::*;
#(
  parameter int unsigned JOINT_COUNT = JOINT_COUNT_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_t    cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PREP = 8'b0000_0010,
    S_MAX  = 8'b0000_0100,
    S_CHK  = 8'b0000_1000,
    S_MUL  = 8'b0001_0000,
    S_DIV  = 8'b0010_0000,
    S_ADD  = 8'b0100_0000,
    S_FIN  = 8'b1000_0000
  } state_e;

  state_e               state_q, state_d;
  logic [IDX_W-1:0]     j_q, j_d;
  logic [DIV_CNT_W-1:0] bit_q, bit_d;
  logic                 out_valid_q, out_valid_d;
  logic                 last_joint;

  assign last_joint = j_q == IDX_W'(JOINT_COUNT - 1);

  // next state and commands
  always_comb begin
    state_d    = state_q;
    j_d        = j_q;
    bit_d      = bit_q;
    cmd_o      = '0;
    cmd_o.idx  = j_q;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_PREP;
        end
      end
      S_PREP: begin
        cmd_o.prep = 1'b1;
        j_d        = '0;
        state_d    = status_i.active ? S_MAX : S_FIN;
      end
      S_MAX: begin
        cmd_o.max_step = 1'b1;
        if (last_joint) begin
          j_d     = '0;
          state_d = S_CHK;
        end else begin
          j_d = j_q + 1'b1;
        end
      end
      S_CHK: begin
        cmd_o.chk = 1'b1;
        state_d   = status_i.exceeds ? S_MUL : S_ADD;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        bit_d     = '0;
        state_d   = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (bit_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_ADD;
        end else begin
          bit_d = bit_q + 1'b1;
        end
      end
      S_ADD: begin
        cmd_o.add = 1'b1;
        if (last_joint) begin
          state_d = S_FIN;
        end else begin
          j_d     = j_q + 1'b1;
          state_d = status_i.scaled ? S_MUL : S_ADD;
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output valid flag
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      j_q         <= '0;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      j_q         <= j_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule
